### hw/rtl/eqsf_pkg.sv
// ----------------------------------------------------------------------------
// eqsf_pkg
// Shared types and constants of the ellipse quadrant span fill unit.
// ----------------------------------------------------------------------------
`default_nettype none

package eqsf_pkg;

   // field widths
   localparam int RAD_W    = 5;    // radius input
   localparam int COORD_W  = 11;   // corner point input
   localparam int SPAN_W   = 12;   // span x / row output
   localparam int COLOR_W  = 24;   // RGB888
   localparam int CSR_IDX_W = 1;

   // datapath widths
   localparam int SQ_W     = 2 * RAD_W;        // radius squared
   localparam int V_W      = RAD_W + 2;        // signed step variables
   localparam int P_W      = SQ_W + RAD_W + 3; // signed running products
   localparam int S_W      = 24;               // signed decision variable
   localparam int MUL_A_W  = SQ_W + 1;
   localparam int MUL_B_W  = RAD_W + 3;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

   // span count limit per request
   localparam int SPAN_LIMIT = 64;
   localparam int CNT_W      = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DRAW_COLOR       = 1'b0,
      CSR_BACKGROUND_COLOR = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_R1_S,
      ST_R1_P,
      ST_R1_LD,
      ST_RUN,
      ST_R2_S,
      ST_R2_P,
      ST_R2_LD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic signed [SPAN_W-1:0] x;
      logic signed [SPAN_W-1:0] y;
      logic [RAD_W-1:0]         width;
      logic [COLOR_W-1:0]       color;
   } span_type;

endpackage

`default_nettype wire

### hw/rtl/ellipse_quadrant_span_fill_unit.sv
// ----------------------------------------------------------------------------
// ellipse_quadrant_span_fill_unit
// Midpoint ellipse quadrant filler: turns one rounded-corner request into a
// run of horizontal spans, the last one marked.
// ----------------------------------------------------------------------------
//
//   channel  dir   handshake          payload
//   -------  ----  -----------------  ------------------------------------------
//   req_     in    req_valid/ready    corner, corner_x/y, radius_x/y, fill_flag
//   rsp_     out   rsp_valid/ready    span_x, span_y, span_width, span_color,
//                                     last_span
//   csr_     in    csr_valid/ready    csr_index, csr_data (always ready)
//
// A request with a radius below 2 is taken and gives no span.
// Otherwise: after the accepting cycle, the setup states SQ_X, SQ_Y, R1_S, R1_P,
// R1_LD (two squares, two products on the shared multiplier, a load), the region
// one midpoint steps in RUN, R2_S, R2_P, R2_LD to set up region two, its steps,
// and FINISH to release the last span.
// A step that yields a span waits while the held span is full and the output
// register is full and not being taken. Reset is synchronous; it returns the
// sequencer to idle, drops any span in flight and restores the color registers.
//
`default_nettype none

module ellipse_quadrant_span_fill_unit
   import eqsf_pkg::*;
#(
   parameter int MAX_RADIUS = 31
)(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_corner,
   input  wire logic signed [COORD_W-1:0] req_corner_x,
   input  wire logic signed [COORD_W-1:0] req_corner_y,
   input  wire logic [RAD_W-1:0]          req_radius_x,
   input  wire logic [RAD_W-1:0]          req_radius_y,
   input  wire logic                      req_fill_flag,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [SPAN_W-1:0]       rsp_span_x,
   output logic signed [SPAN_W-1:0]       rsp_span_y,
   output logic [RAD_W-1:0]               rsp_span_width,
   output logic [COLOR_W-1:0]             rsp_span_color,
   output logic                           rsp_last_span,

   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [COLOR_W-1:0]        csr_data
);

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   state_type                 state_ff, state_in;
   logic [1:0]                corner_ff, corner_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [COLOR_W-1:0]        color_ff, color_in;
   logic [RAD_W-1:0]          rx_ff, rx_in, ry_ff, ry_in;
   logic [SQ_W-1:0]           rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [SQ_W-1:0]           sq_a_ff, sq_a_in, sq_b_ff, sq_b_in;
   logic signed [S_W-1:0]     s_ff, s_in, k6_ff, k6_in;
   logic signed [P_W-1:0]     p_inc_ff, p_inc_in, p_dec_ff, p_dec_in;
   logic signed [V_W-1:0]     inc_ff, inc_in, dec_ff, dec_in;
   logic                      region2_ff, region2_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   span_type                  hold_ff, hold_in;
   logic                      hold_valid_ff, hold_valid_in;
   span_type                  out_ff, out_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_valid_ff, out_valid_in;
   logic [COLOR_W-1:0]        draw_ff, draw_in, bg_ff, bg_in;

   // ------------------------------------------------------------------
   // shared multiplier
   // ------------------------------------------------------------------
   mul_req_type               mul_req;
   logic signed [MUL_P_W-1:0] mul_q;

   eqsf_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .mul_q   (mul_q)
   );

   // ------------------------------------------------------------------
   // combinational helpers
   // ------------------------------------------------------------------
   logic [RAD_W-1:0]          rx_sat, ry_sat;
   logic signed [S_W-1:0]     rx2_s, ry2_s, sq_a_s, mul_s, p_inc_s, p_dec_s;
   logic signed [S_W-1:0]     s_bump;
   logic signed [P_W-1:0]     sq_a_p, sq_b_p;
   logic signed [V_W-1:0]     w_v, yo_v;
   logic signed [SPAN_W-1:0]  cx12, cy12, w12, yo12;
   logic                      cont, emit, out_free, stall;
   span_type                  new_span;

   // clamp the radii before anything else sees them
   assign rx_sat = (32'(req_radius_x) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : req_radius_x;
   assign ry_sat = (32'(req_radius_y) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : req_radius_y;

   assign rx2_s   = $signed(S_W'(rx2_ff));
   assign ry2_s   = $signed(S_W'(ry2_ff));
   assign sq_a_s  = $signed(S_W'(sq_a_ff));
   assign sq_a_p  = $signed(P_W'(sq_a_ff));
   assign sq_b_p  = $signed(P_W'(sq_b_ff));
   assign mul_s   = S_W'(mul_q);
   assign p_inc_s = S_W'(p_inc_ff);
   assign p_dec_s = S_W'(p_dec_ff);

   // region one steps x (inc) and walks y down (dec); region two swaps roles
   assign cont = (p_inc_ff <= p_dec_ff);
   assign w_v  = region2_ff ? dec_ff : inc_ff;
   assign yo_v = region2_ff ? inc_ff : dec_ff;
   assign emit = (w_v > V_W'(0));

   // midpoint correction when s is non-negative: 4*A - 4*(A*dec)
   assign s_bump = (s_ff >= S_W'(0)) ? ((sq_a_s <<< 2) - (p_dec_s <<< 2)) : S_W'(0);

   // place the span by corner: odd corners open right, upper bit picks bottom rows
   assign cx12 = SPAN_W'(cx_ff);
   assign cy12 = SPAN_W'(cy_ff);
   assign w12  = SPAN_W'(w_v);
   assign yo12 = SPAN_W'(yo_v);

   always_comb begin
      new_span.x     = corner_ff[0] ? cx12 : (cx12 - w12);
      new_span.y     = corner_ff[1] ? (cy12 + yo12 - SPAN_W'(1)) : (cy12 - yo12);
      new_span.width = RAD_W'(w_v);
      new_span.color = color_ff;
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign stall    = emit && hold_valid_ff && !out_free;

   // ------------------------------------------------------------------
   // state register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // other registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         draw_ff       <= COLOR_W'(24'hFF_FFFF);
         bg_ff         <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
         draw_ff       <= draw_in;
         bg_ff         <= bg_in;
      end
      corner_ff   <= corner_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      color_ff    <= color_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      rx2_ff      <= rx2_in;
      ry2_ff      <= ry2_in;
      sq_a_ff     <= sq_a_in;
      sq_b_ff     <= sq_b_in;
      s_ff        <= s_in;
      k6_ff       <= k6_in;
      p_inc_ff    <= p_inc_in;
      p_dec_ff    <= p_dec_in;
      inc_ff      <= inc_in;
      dec_ff      <= dec_in;
      region2_ff  <= region2_in;
      cnt_ff      <= cnt_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   // ------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      draw_in = draw_ff;
      bg_in   = bg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DRAW_COLOR:       draw_in = csr_data;
            CSR_BACKGROUND_COLOR: bg_in   = csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // sequencer: next state, datapath loads and multiplier operands
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      corner_in     = corner_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      color_in      = color_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      rx2_in        = rx2_ff;
      ry2_in        = ry2_ff;
      sq_a_in       = sq_a_ff;
      sq_b_in       = sq_b_ff;
      s_in          = s_ff;
      k6_in         = k6_ff;
      p_inc_in      = p_inc_ff;
      p_dec_in      = p_dec_ff;
      inc_in        = inc_ff;
      dec_in        = dec_ff;
      region2_in    = region2_ff;
      cnt_in        = cnt_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      mul_req       = '0;
      req_ready     = 1'b0;

      // drop the output transaction once taken
      out_valid_in = out_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               corner_in  = req_corner;
               cx_in      = req_corner_x;
               cy_in      = req_corner_y;
               rx_in      = rx_sat;
               ry_in      = ry_sat;
               color_in   = req_fill_flag ? draw_ff : bg_ff;
               cnt_in     = '0;
               region2_in = 1'b0;
               // radii below 2 draw nothing: stay idle
               if (rx_sat >= RAD_W'(2) && ry_sat >= RAD_W'(2)) begin
                  state_in = ST_SQ_X;
               end
            end
         end

         ST_SQ_X: begin
            mul_req.a = MUL_A_W'(rx_ff);
            mul_req.b = MUL_B_W'(rx_ff);
            state_in  = ST_SQ_Y;
         end

         ST_SQ_Y: begin
            mul_req.a = MUL_A_W'(ry_ff);
            mul_req.b = MUL_B_W'(ry_ff);
            rx2_in    = SQ_W'(mul_q);
            state_in  = ST_R1_S;
         end

         ST_R1_S: begin
            // rx2 * (1 - 2*ry)
            mul_req.a = MUL_A_W'(rx2_ff);
            mul_req.b = MUL_B_W'(1) - $signed({2'b00, ry_ff, 1'b0});
            ry2_in    = SQ_W'(mul_q);
            state_in  = ST_R1_P;
         end

         ST_R1_P: begin
            mul_req.a = MUL_A_W'(rx2_ff);
            mul_req.b = MUL_B_W'(ry_ff);
            s_in      = (ry2_s <<< 1) + mul_s;
            state_in  = ST_R1_LD;
         end

         ST_R1_LD: begin
            p_dec_in = P_W'(mul_q);
            p_inc_in = '0;
            inc_in   = '0;
            dec_in   = V_W'(ry_ff);
            sq_a_in  = rx2_ff;
            sq_b_in  = ry2_ff;
            k6_in    = (ry2_s <<< 2) + (ry2_s <<< 1);
            state_in = ST_RUN;
         end

         ST_RUN: begin
            if (!cont) begin
               state_in = region2_ff ? ST_FINISH : ST_R2_S;
            end else if (!stall) begin
               // advance one midpoint step
               s_in     = s_ff + s_bump + (p_inc_s <<< 2) + k6_ff;
               inc_in   = inc_ff + V_W'(1);
               p_inc_in = p_inc_ff + sq_b_p;
               if (s_ff >= S_W'(0)) begin
                  dec_in   = dec_ff - V_W'(1);
                  p_dec_in = p_dec_ff - sq_a_p;
               end
               if (emit) begin
                  // push the held span out; it is not the last one
                  if (hold_valid_ff) begin
                     out_in       = hold_ff;
                     out_last_in  = 1'b0;
                     out_valid_in = 1'b1;
                  end
                  hold_in       = new_span;
                  hold_valid_in = 1'b1;
                  cnt_in        = cnt_ff + CNT_W'(1);
                  if (cnt_ff == CNT_W'(SPAN_LIMIT - 1)) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end

         ST_R2_S: begin
            // ry2 * (1 - 2*rx)
            mul_req.a = MUL_A_W'(ry2_ff);
            mul_req.b = MUL_B_W'(1) - $signed({2'b00, rx_ff, 1'b0});
            state_in  = ST_R2_P;
         end

         ST_R2_P: begin
            mul_req.a = MUL_A_W'(ry2_ff);
            mul_req.b = MUL_B_W'(rx_ff);
            s_in      = (rx2_s <<< 1) + mul_s;
            state_in  = ST_R2_LD;
         end

         ST_R2_LD: begin
            p_dec_in   = P_W'(mul_q);
            p_inc_in   = '0;
            inc_in     = '0;
            dec_in     = V_W'(rx_ff);
            sq_a_in    = ry2_ff;
            sq_b_in    = rx2_ff;
            k6_in      = (rx2_s <<< 2) + (rx2_s <<< 1);
            region2_in = 1'b1;
            state_in   = ST_RUN;
         end

         ST_FINISH: begin
            // release the held span marked as last
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in        = hold_ff;
               out_last_in   = 1'b1;
               out_valid_in  = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // result ports
   // ------------------------------------------------------------------
   assign rsp_valid      = out_valid_ff;
   assign rsp_span_x     = out_ff.x;
   assign rsp_span_y     = out_ff.y;
   assign rsp_span_width = out_ff.width;
   assign rsp_span_color = out_ff.color;
   assign rsp_last_span  = out_last_ff;

endmodule

`default_nettype wire

### hw/rtl/eqsf_mul.sv
// ----------------------------------------------------------------------------
// eqsf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module eqsf_mul
   import eqsf_pkg::*;
(
   input  wire logic                      clock,
   input  wire mul_req_type               mul_req,
   output logic signed [MUL_P_W-1:0]      mul_q
);

   logic signed [MUL_P_W-1:0] prod_in;
   logic signed [MUL_P_W-1:0] prod_ff;

   assign prod_in = MUL_P_W'(mul_req.a) * MUL_P_W'(mul_req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_q = prod_ff;

endmodule

`default_nettype wire

### hw/rtl/eqsf_checker.sv
// ----------------------------------------------------------------------------
// eqsf_checker
// Port-level assertions for the ellipse quadrant span fill unit.
// ----------------------------------------------------------------------------
`default_nettype none

module eqsf_checker
   import eqsf_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic [RAD_W-1:0]          req_radius_x,
   input wire logic [RAD_W-1:0]          req_radius_y,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic signed [SPAN_W-1:0]  rsp_span_x,
   input wire logic signed [SPAN_W-1:0]  rsp_span_y,
   input wire logic [RAD_W-1:0]          rsp_span_width,
   input wire logic [COLOR_W-1:0]        rsp_span_color,
   input wire logic                      rsp_last_span
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_span_x) && $stable(rsp_span_y)
         && $stable(rsp_span_width) && $stable(rsp_span_color) && $stable(rsp_last_span))
      else $error("stalled result transaction changed");

   // a drawable request closes the input once it is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_radius_x >= RAD_W'(2) && req_radius_y >= RAD_W'(2)
         |=> !req_ready)
      else $error("request accepted while a quadrant is in progress");

   // the input only closes after taking a transaction
   a_ready_falls_on_accept: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid && req_ready))
      else $error("req_ready dropped without a request");

   // every emitted span covers at least one pixel
   a_nonzero_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_span_width != RAD_W'(0))
      else $error("zero-width span emitted");

   // nothing is presented right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ellipse_quadrant_span_fill_unit eqsf_checker u_eqsf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_radius_x   (req_radius_x),
   .req_radius_y   (req_radius_y),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_span_x     (rsp_span_x),
   .rsp_span_y     (rsp_span_y),
   .rsp_span_width (rsp_span_width),
   .rsp_span_color (rsp_span_color),
   .rsp_last_span  (rsp_last_span)
);

`default_nettype wire

### sim/eqsf_span_checker.sv
// ----------------------------------------------------------------------------
// eqsf_span_checker
// Watches the request, span and register channels of the quadrant span fill
// unit, predicts the span run of every accepted request with its own midpoint
// walk, and compares each accepted span field by field with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module eqsf_span_checker
   import eqsf_pkg::*;
#(
   parameter int MAX_RADIUS = 31
)(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic [1:0]                req_corner,
   input  wire logic signed [COORD_W-1:0] req_corner_x,
   input  wire logic signed [COORD_W-1:0] req_corner_y,
   input  wire logic [RAD_W-1:0]          req_radius_x,
   input  wire logic [RAD_W-1:0]          req_radius_y,
   input  wire logic                      req_fill_flag,

   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic signed [SPAN_W-1:0]  rsp_span_x,
   input  wire logic signed [SPAN_W-1:0]  rsp_span_y,
   input  wire logic [RAD_W-1:0]          rsp_span_width,
   input  wire logic [COLOR_W-1:0]        rsp_span_color,
   input  wire logic                      rsp_last_span,

   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [COLOR_W-1:0]        csr_data,

   output int                             fail_count,
   output int                             span_backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      span_type span;
      logic     last;
   } span_expect_type;

   span_expect_type    expected_spans[$];
   logic [COLOR_W-1:0] draw_color_q;
   logic [COLOR_W-1:0] background_color_q;
   int                 mismatches = 0;

   // place one step of the walk; zero widths and spans past the limit drop out
   function automatic void queue_span(input logic [1:0] corner, input int cx, input int cy,
                                      input int w, input int row_off,
                                      input logic [COLOR_W-1:0] color, inout int count);
      span_expect_type rec;
      int              sx;
      int              sy;
      if (w <= 0 || count >= SPAN_LIMIT) return;
      sx = corner[0] ? cx : cx - w;
      sy = corner[1] ? cy + row_off - 1 : cy - row_off;
      rec.span.x     = sx[SPAN_W-1:0];
      rec.span.y     = sy[SPAN_W-1:0];
      rec.span.width = w[RAD_W-1:0];
      rec.span.color = color;
      rec.last       = 1'b0;
      expected_spans.push_back(rec);
      count++;
   endfunction

   function automatic void predict_quadrant_spans(input logic [1:0] corner,
                                                  input logic signed [COORD_W-1:0] cx_in,
                                                  input logic signed [COORD_W-1:0] cy_in,
                                                  input logic [RAD_W-1:0] rx_in,
                                                  input logic [RAD_W-1:0] ry_in,
                                                  input logic [COLOR_W-1:0] color);
      int              cx;
      int              cy;
      int              rx;
      int              ry;
      int              rx_sq;
      int              ry_sq;
      int              px;
      int              py;
      int              dec;
      int              count;
      span_expect_type tail;
      cx = cx_in;
      cy = cy_in;
      rx = (rx_in > MAX_RADIUS) ? MAX_RADIUS : int'(rx_in);
      ry = (ry_in > MAX_RADIUS) ? MAX_RADIUS : int'(ry_in);
      if (rx < 2 || ry < 2) return;
      rx_sq = rx * rx;
      ry_sq = ry * ry;
      count = 0;

      // region one: x advances every step
      px  = 0;
      py  = ry;
      dec = 2 * ry_sq + rx_sq * (1 - 2 * ry);
      while (ry_sq * px <= rx_sq * py) begin
         queue_span(corner, cx, cy, px, py, color, count);
         if (dec >= 0) begin
            dec += 4 * rx_sq * (1 - py);
            py--;
         end
         dec += ry_sq * (4 * px + 6);
         px++;
      end

      // region two: y advances every step
      px  = rx;
      py  = 0;
      dec = 2 * rx_sq + ry_sq * (1 - 2 * rx);
      while (rx_sq * py <= ry_sq * px) begin
         queue_span(corner, cx, cy, px, py, color, count);
         if (dec >= 0) begin
            dec += 4 * ry_sq * (1 - px);
            px--;
         end
         dec += rx_sq * (4 * py + 6);
         py++;
      end

      if (count > 0) begin
         tail      = expected_spans.pop_back();
         tail.last = 1'b1;
         expected_spans.push_back(tail);
      end
   endfunction

   always @(posedge clock) begin : watch
      span_expect_type want;
      if (reset) begin
         draw_color_q       = 24'hFFFFFF;
         background_color_q = 24'h000000;
         expected_spans.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DRAW_COLOR)
               draw_color_q = csr_data;
            else if (csr_index == CSR_BACKGROUND_COLOR)
               background_color_q = csr_data;
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_spans.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected span x=%0d y=%0d width=%0d color=%06h last=%0b",
                           rsp_span_x, rsp_span_y, rsp_span_width, rsp_span_color,
                           rsp_last_span);
            end else begin
               want = expected_spans.pop_front();
               if (rsp_span_x !== want.span.x || rsp_span_y !== want.span.y ||
                   rsp_span_width !== want.span.width ||
                   rsp_span_color !== want.span.color || rsp_last_span !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("span mismatch: expected x=%0d y=%0d width=%0d color=%06h last=%0b",
                              want.span.x, want.span.y, want.span.width, want.span.color,
                              want.last);
                     $display("                    got x=%0d y=%0d width=%0d color=%06h last=%0b",
                              rsp_span_x, rsp_span_y, rsp_span_width, rsp_span_color,
                              rsp_last_span);
                  end
               end
            end
         end

         if (req_valid && req_ready)
            predict_quadrant_spans(req_corner, req_corner_x, req_corner_y, req_radius_x,
                                   req_radius_y,
                                   req_fill_flag ? draw_color_q : background_color_q);
      end
      fail_count   <= mismatches;
      span_backlog <= expected_spans.size();
   end

endmodule

### sim/ellipse_quadrant_span_fill_unit_tb.sv
// ----------------------------------------------------------------------------
// ellipse_quadrant_span_fill_unit_tb
// Drives corner requests and color register writes into the quadrant span
// fill unit under several idle and stall patterns; a checker beside the block
// predicts and compares every span, and this top gives the verdict.
// ----------------------------------------------------------------------------
module ellipse_quadrant_span_fill_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import eqsf_pkg::*;

   localparam int MAX_RADIUS    = 31;
   // closing wait: setup plus one step per radius pixel, with margin
   localparam int SETTLE_CYCLES = 100;
   // longest stretch with no transaction on any channel
   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 300;

   logic                      clock;
   logic                      reset;

   logic                      req_valid;
   logic                      req_ready;
   logic [1:0]                req_corner;
   logic signed [COORD_W-1:0] req_corner_x;
   logic signed [COORD_W-1:0] req_corner_y;
   logic [RAD_W-1:0]          req_radius_x;
   logic [RAD_W-1:0]          req_radius_y;
   logic                      req_fill_flag;

   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [SPAN_W-1:0]  rsp_span_x;
   logic signed [SPAN_W-1:0]  rsp_span_y;
   logic [RAD_W-1:0]          rsp_span_width;
   logic [COLOR_W-1:0]        rsp_span_color;
   logic                      rsp_last_span;

   logic                      csr_valid;
   logic                      csr_ready;
   csr_index_type             csr_index;
   logic [COLOR_W-1:0]        csr_data;

   int                        fail_count;
   int                        span_backlog;

   // receiver behavior, set by the stimulus between phases
   int                        rsp_stall_pct = 0;
   int                        hold_request  = 0;
   int                        watchdog_count = 0;

   ellipse_quadrant_span_fill_unit #(
      .MAX_RADIUS(MAX_RADIUS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_corner     (req_corner),
      .req_corner_x   (req_corner_x),
      .req_corner_y   (req_corner_y),
      .req_radius_x   (req_radius_x),
      .req_radius_y   (req_radius_y),
      .req_fill_flag  (req_fill_flag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_span_x     (rsp_span_x),
      .rsp_span_y     (rsp_span_y),
      .rsp_span_width (rsp_span_width),
      .rsp_span_color (rsp_span_color),
      .rsp_last_span  (rsp_last_span),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   eqsf_span_checker #(
      .MAX_RADIUS(MAX_RADIUS)
   ) span_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_corner     (req_corner),
      .req_corner_x   (req_corner_x),
      .req_corner_y   (req_corner_y),
      .req_radius_x   (req_radius_x),
      .req_radius_y   (req_radius_y),
      .req_fill_flag  (req_fill_flag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_span_x     (rsp_span_x),
      .rsp_span_y     (rsp_span_y),
      .rsp_span_width (rsp_span_width),
      .rsp_span_color (rsp_span_color),
      .rsp_last_span  (rsp_last_span),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .span_backlog   (span_backlog)
   );

   always #10 clock = ~clock;

   // Receiver: pick up a hold-off request and count it down here, otherwise
   // stall at the rate of the current phase. Drive only at the falling edge.
   always begin : span_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: restart on any transaction, give up after a long dead stretch.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         watchdog_count <= 0;
      end else if (watchdog_count >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         watchdog_count <= watchdog_count + 1;
      end
   end

   // Offer one request after an optional idle gap; return at the edge that
   // takes it. Valid stays high so a back-to-back request needs no re-raise.
   task automatic send_request(input int gap, input logic [1:0] corner,
                               input logic signed [COORD_W-1:0] cx,
                               input logic signed [COORD_W-1:0] cy,
                               input logic [RAD_W-1:0] rx, input logic [RAD_W-1:0] ry,
                               input logic fill);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_corner    <= corner;
      req_corner_x  <= cx;
      req_corner_y  <= cy;
      req_radius_x  <= rx;
      req_radius_y  <= ry;
      req_fill_flag <= fill;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Random request; one in ten radii falls below the drawing threshold.
   task automatic send_random(input int idle_pct);
      int               gap;
      logic [RAD_W-1:0] rx;
      logic [RAD_W-1:0] ry;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      rx = ($urandom_range(9) == 0) ? RAD_W'($urandom_range(1))
                                    : RAD_W'($urandom_range(2 ** RAD_W - 1, 2));
      ry = ($urandom_range(9) == 0) ? RAD_W'($urandom_range(1))
                                    : RAD_W'($urandom_range(2 ** RAD_W - 1, 2));
      send_request(gap, 2'($urandom_range(3)), COORD_W'($urandom), COORD_W'($urandom),
                   rx, ry, 1'($urandom_range(1)));
   endtask

   task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
      rsp_stall_pct = stall_pct;
      repeat (count) send_random(idle_pct);
   endtask

   // Drop valid, wait for every predicted span, then let the block finish
   // any request that yields nothing. Ends on a rising edge.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (span_backlog != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [COLOR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_corner    = '0;
      req_corner_x  = '0;
      req_corner_y  = '0;
      req_radius_x  = '0;
      req_radius_y  = '0;
      req_fill_flag = 1'b0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_DRAW_COLOR;
      csr_data      = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset colors, full-rate receiver.
      rsp_stall_pct = 0;
      // radius below the threshold on either axis: no spans
      send_request(0, 2'd0, 0, 0, 0, 0, 1'b1);
      send_request(0, 2'd1, 5, -7, 1, 31, 1'b0);
      send_request(0, 2'd2, -3, 9, 31, 1, 1'b1);
      send_request(0, 2'd3, 100, 100, 0, 7, 1'b0);
      // largest radii on every corner, corner point at the coordinate extremes
      send_request(0, 2'd0, -1024, -1024, 31, 31, 1'b1);
      send_request(0, 2'd1, 1023, -1024, 31, 31, 1'b0);
      send_request(0, 2'd2, -1024, 1023, 31, 31, 1'b1);
      send_request(0, 2'd3, 1023, 1023, 31, 31, 1'b0);
      // smallest drawable ellipse on every corner
      send_request(0, 2'd0, -1, -1, 2, 2, 1'b0);
      send_request(0, 2'd1, 0, 0, 2, 2, 1'b1);
      send_request(0, 2'd2, 1, -1, 2, 2, 1'b0);
      send_request(0, 2'd3, -1, 1, 2, 2, 1'b1);
      // flat and tall extremes, zero-width steps among them
      send_request(0, 2'd1, 12, 34, 31, 2, 1'b1);
      send_request(0, 2'd2, -56, 78, 2, 31, 1'b0);
      send_request(0, 2'd3, 300, -300, 3, 17, 1'b0);
      send_request(0, 2'd0, -500, 500, 20, 5, 1'b1);
      settle_block();

      // Extreme colors swapped from reset; no idling anywhere.
      write_register(CSR_DRAW_COLOR, 24'h000000);
      write_register(CSR_BACKGROUND_COLOR, 24'hFFFFFF);
      run_phase(60, 0, 0);
      settle_block();

      // Random colors; sender idles about two thirds of the time.
      write_register(CSR_DRAW_COLOR, COLOR_W'($urandom));
      write_register(CSR_BACKGROUND_COLOR, COLOR_W'($urandom));
      run_phase(60, 67, 0);
      settle_block();

      // Receiver stalls about two thirds of the time.
      write_register(CSR_BACKGROUND_COLOR, COLOR_W'($urandom));
      run_phase(60, 0, 67);

      // Back pressure: hold the receiver off after the first transaction while
      // requests keep coming, so the block backs up and stalls its input.
      rsp_stall_pct = 0;
      send_random(0);
      hold_request = HOLD_CYCLES;
      repeat (14) send_random(0);
      settle_block();

      // Both sides idle about a third of the time.
      write_register(CSR_DRAW_COLOR, COLOR_W'($urandom));
      write_register(CSR_BACKGROUND_COLOR, 24'h000000);
      run_phase(55, 36, 36);
      settle_block();

      if (fail_count == 0 && span_backlog == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
